@@ sv/stb_pkg.sv @@
// stb_pkg: request and response types, command and status codes for the soft timer bank
// no dependencies; imported by soft_timer_bank
`default_nettype none

package stb_pkg;

	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_CREATE  = 3'd1;
	localparam logic [2:0] CMD_DELETE  = 3'd2;
	localparam logic [2:0] CMD_CHECK   = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;
	localparam logic [2:0] CMD_ELAPSED = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_IN_USE   = 2'd1;
	localparam logic [1:0] ST_NOT_USED = 2'd2;
	localparam logic [1:0] ST_BAD_ID   = 2'd3;

	localparam logic [30:0] RUN_WRAP = 31'h7fffffff;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  timer_id;
		logic [31:0] period;
		logic        auto_reload;
		logic [30:0] last_time;
	} stb_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        expired;
		logic [7:0]  expired_mask;
		logic [30:0] time_value;
	} stb_rsp_t;

endpackage

`default_nettype wire

@@ sv/stb_ram.sv @@
// stb_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module stb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/soft_timer_bank.sv @@
// soft_timer_bank: bank of countdown timers with a run-time counter
// uses stb_pkg and stb_ram
//
// One request gives exactly one response. Counts and reload values live in one
// ram with a registered read; per-timer in-use, mode and expired bits are
// flip-flops, and an entry not in use reads as zero. A tick walks every timer
// through the ram, reading the next entry while writing back the current one
// when its count is nonzero. A new request is taken while the previous
// response still waits in the output register.
`default_nettype none

module soft_timer_bank
	import stb_pkg::*;
#(
	parameter int TIMER_COUNT = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire stb_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output stb_rsp_t      rsp
);

	localparam int IDX_W = TIMER_COUNT > 1 ? $clog2(TIMER_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);
	localparam logic [4:0] ID_LIMIT = 5'(TIMER_COUNT);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_TICK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;

	logic [TIMER_COUNT-1:0] in_use_q;
	logic [TIMER_COUNT-1:0] mode_q;
	logic [TIMER_COUNT-1:0] exp_q;
	logic [30:0]            run_time_q;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	stb_rsp_t res_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [63:0]      ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [63:0]      ram_rdata;

	logic             accept;
	logic             id_ok;
	logic [IDX_W-1:0] id_idx;
	logic             used;
	logic [31:0]      cnt_cur;
	logic [31:0]      rld_cur;
	logic             hit;
	logic [31:0]      cnt_new;
	logic [31:0]      diff;
	logic [30:0]      diff_wrap;
	logic             rsp_load;
	stb_rsp_t         res_d;

	stb_ram #(
		.WIDTH (64),
		.DEPTH (TIMER_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign id_ok     = {1'b0, req.timer_id} < ID_LIMIT;
	assign id_idx    = req.timer_id[IDX_W-1:0];
	assign used      = id_ok && in_use_q[id_idx];

	// entry data arriving from the ram this cycle
	assign cnt_cur = in_use_q[idx_s1] ? ram_rdata[31:0] : 32'd0;
	assign rld_cur = in_use_q[idx_s1] ? ram_rdata[63:32] : 32'd0;
	assign hit     = (cnt_cur == 32'd1);
	assign cnt_new = hit ? (mode_q[idx_s1] ? rld_cur : 32'd0) : cnt_cur - 32'd1;

	assign diff      = {1'b0, run_time_q} - {1'b0, req.last_time};
	assign diff_wrap = run_time_q + ~req.last_time;

	assign rsp_load = (state_q == S_FIN) && (!rsp_valid || rsp_ready);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = {rld_cur, cnt_new};
		ram_re    = 1'b0;
		ram_raddr = idx_s1 + IDX_W'(1);
		if (accept && req.command == CMD_CREATE && id_ok && !used) begin
			ram_we    = 1'b1;
			ram_waddr = id_idx;
			ram_wdata = {req.period, req.period};
		end else if (vld_s1 && cnt_cur != 32'd0) begin
			ram_we = 1'b1;
		end
		if (accept && req.command == CMD_TICK) begin
			ram_re    = 1'b1;
			ram_raddr = '0;
		end else if (vld_s1 && idx_s1 != LAST_IDX) begin
			ram_re = 1'b1;
		end
	end

	always_comb begin
		res_d = '0;
		unique case (req.command) inside
			CMD_CREATE: begin
				if (!id_ok) begin
					res_d.status = ST_BAD_ID;
				end else if (used) begin
					res_d.status = ST_IN_USE;
				end
			end
			CMD_DELETE, CMD_CHECK: begin
				if (!id_ok) begin
					res_d.status = ST_BAD_ID;
				end else if (!used) begin
					res_d.status = ST_NOT_USED;
				end else if (req.command == CMD_CHECK) begin
					res_d.expired = exp_q[id_idx];
				end
			end
			CMD_READ: begin
				res_d.time_value = run_time_q;
			end
			CMD_ELAPSED: begin
				res_d.time_value = diff[31] ? diff_wrap : diff[30:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_use_q   <= '0;
			mode_q     <= '0;
			exp_q      <= '0;
			run_time_q <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			rsp_valid  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command == CMD_TICK) begin
							state_q    <= S_TICK;
							vld_s1     <= 1'b1;
							idx_s1     <= '0;
							run_time_q <= (run_time_q == RUN_WRAP - 31'd1) ?
								'0 : run_time_q + 31'd1;
						end else begin
							state_q <= S_FIN;
						end
						if (req.command == CMD_CREATE && id_ok && !used) begin
							in_use_q[id_idx] <= 1'b1;
							mode_q[id_idx]   <= req.auto_reload;
							exp_q[id_idx]    <= 1'b0;
						end
						if (req.command == CMD_DELETE && used) begin
							in_use_q[id_idx] <= 1'b0;
							mode_q[id_idx]   <= 1'b0;
						end
					end
				end
				S_TICK: begin
					if (vld_s1 && hit) begin
						exp_q[idx_s1] <= 1'b1;
					end
					if (idx_s1 == LAST_IDX) begin
						vld_s1  <= 1'b0;
						state_q <= S_FIN;
					end else begin
						idx_s1 <= idx_s1 + IDX_W'(1);
					end
				end
				S_FIN: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end else if (state_q == S_TICK && hit) begin
			res_q.expired_mask <= res_q.expired_mask | (8'd1 << idx_s1);
		end
		if (rsp_load) begin
			rsp <= res_q;
		end
	end

	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("ram read and write hit the same entry");

	a_walk_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == S_TICK)
		else $error("timer walk active outside tick");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && rsp_valid && !rsp_ready |=> state_q == S_FIN)
		else $error("result dropped while response stalled");

endmodule

`default_nettype wire

@@ sim/soft_timer_bank_tb.sv @@
// soft_timer_bank_tb: self-checking bench for the soft timer bank, directed and random requests
// predicts each response from its own copy of the timer state; depends on stb_pkg, soft_timer_bank
`timescale 1ns / 100ps

module soft_timer_bank_tb;
	import stb_pkg::*;

	localparam int TIMERS = 8;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	stb_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	stb_rsp_t rsp;

	// predicted timer state
	logic [31:0] timer_left [TIMERS];
	logic [31:0] timer_reload [TIMERS];
	logic        timer_fired [TIMERS];
	logic        timer_auto [TIMERS];
	logic        timer_busy [TIMERS];
	logic [30:0] run_count;

	stb_rsp_t pending_timer_rsp [$];
	stb_rsp_t want_rsp;
	int       mismatch_count = 0;
	int       rsp_seen = 0;
	int       sender_idle_pct = 0;
	int       rsp_stall_pct = 0;

	soft_timer_bank #(
		.TIMER_COUNT(TIMERS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	initial begin
		#(2_000_000);
		$display("tb: failure");
		$finish;
	end

	function automatic stb_rsp_t timer_command_result(input stb_req_t r);
		stb_rsp_t o;
		logic     id_ok;
		o = '0;
		id_ok = r.timer_id < TIMERS;
		case (r.command)
			CMD_TICK: begin
				run_count = run_count + 31'd1;
				if (run_count == RUN_WRAP) run_count = '0;
				for (int i = 0; i < TIMERS; i++) begin
					if (timer_left[i] != 0) begin
						timer_left[i] = timer_left[i] - 32'd1;
						if (timer_left[i] == 0) begin
							timer_fired[i] = 1'b1;
							if (timer_auto[i]) timer_left[i] = timer_reload[i];
							o.expired_mask[i] = 1'b1;
						end
					end
				end
			end
			CMD_CREATE: begin
				if (!id_ok) o.status = ST_BAD_ID;
				else if (timer_busy[r.timer_id]) o.status = ST_IN_USE;
				else begin
					timer_left[r.timer_id] = r.period;
					timer_reload[r.timer_id] = r.period;
					timer_fired[r.timer_id] = 1'b0;
					timer_auto[r.timer_id] = r.auto_reload;
					timer_busy[r.timer_id] = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (!id_ok) o.status = ST_BAD_ID;
				else if (!timer_busy[r.timer_id]) o.status = ST_NOT_USED;
				else begin
					timer_left[r.timer_id] = '0;
					timer_reload[r.timer_id] = '0;
					timer_auto[r.timer_id] = 1'b0;
					timer_busy[r.timer_id] = 1'b0;
				end
			end
			CMD_CHECK: begin
				if (!id_ok) o.status = ST_BAD_ID;
				else if (!timer_busy[r.timer_id]) o.status = ST_NOT_USED;
				else o.expired = timer_fired[r.timer_id];
			end
			CMD_READ: begin
				o.time_value = run_count;
			end
			CMD_ELAPSED: begin
				if (run_count >= r.last_time) o.time_value = run_count - r.last_time;
				else o.time_value = RUN_WRAP - r.last_time + run_count;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= 200)
			$display("mismatch on response %0d, %s: got %0h want %0h", rsp_seen, what, got, want);
	endtask

	always @(negedge clk) begin
		rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (pending_timer_rsp.size() == 0) begin
				report_mismatch("no request outstanding", 64'(rsp), 64'd0);
			end else begin
				want_rsp = pending_timer_rsp.pop_front();
				if (rsp.status !== want_rsp.status)
					report_mismatch("status", 64'(rsp.status), 64'(want_rsp.status));
				if (rsp.expired !== want_rsp.expired)
					report_mismatch("expired", 64'(rsp.expired), 64'(want_rsp.expired));
				if (rsp.expired_mask !== want_rsp.expired_mask)
					report_mismatch("expired_mask", 64'(rsp.expired_mask),
						64'(want_rsp.expired_mask));
				if (rsp.time_value !== want_rsp.time_value)
					report_mismatch("time_value", 64'(rsp.time_value),
						64'(want_rsp.time_value));
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input stb_req_t item);
		req = item;
		req_valid = 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_timer_rsp.push_back(timer_command_result(item));
		@(negedge clk);
	endtask

	task automatic sender_gap();
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic issue(input logic [2:0] cmd, input logic [3:0] id, input logic [31:0] period,
			input logic auto_reload, input logic [30:0] last_time);
		stb_req_t r;
		r.command = cmd;
		r.timer_id = id;
		r.period = period;
		r.auto_reload = auto_reload;
		r.last_time = last_time;
		send_request(r);
		sender_gap();
	endtask

	task automatic wait_for_idle_bank();
		req_valid = 1'b0;
		while (pending_timer_rsp.size() != 0) @(negedge clk);
	endtask

	function automatic stb_req_t random_request();
		stb_req_t    r;
		int unsigned pick;
		r.command = 3'($urandom);
		r.timer_id = 4'($urandom);
		r.period = $urandom;
		r.auto_reload = 1'($urandom);
		r.last_time = 31'($urandom);
		pick = $urandom_range(99);
		if (pick < 35) r.command = CMD_TICK;
		else if (pick < 55) r.command = CMD_CREATE;
		else if (pick < 67) r.command = CMD_DELETE;
		else if (pick < 85) r.command = CMD_CHECK;
		else if (pick < 91) r.command = CMD_READ;
		else if (pick < 97) r.command = CMD_ELAPSED;
		else r.command = 3'($urandom_range(6, 7));
		if ($urandom_range(9) != 0) r.timer_id = 4'($urandom_range(TIMERS - 1));
		case ($urandom_range(9))
			0: r.period = '0;
			1: r.period = '1;
			2: begin
			end
			default: r.period = 32'($urandom_range(1, 12));
		endcase
		case ($urandom_range(7))
			0: r.last_time = RUN_WRAP;
			1: r.last_time = run_count;
			2, 3: r.last_time = run_count - 31'($urandom_range(5));
			4: r.last_time = run_count + 31'($urandom_range(1, 5));
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic test_id_and_usage();
		issue(CMD_READ, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_ELAPSED, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_ELAPSED, 4'd0, 32'd0, 1'b0, RUN_WRAP);
		issue(CMD_CHECK, 4'd3, 32'd0, 1'b0, 31'd0);
		issue(CMD_DELETE, 4'd3, 32'd0, 1'b0, 31'd0);
		issue(CMD_CREATE, 4'd8, 32'd5, 1'b1, 31'd0);
		issue(CMD_DELETE, 4'd15, 32'd0, 1'b0, 31'd0);
		issue(CMD_CHECK, 4'd12, 32'd0, 1'b0, 31'd0);
		issue(CMD_CREATE, 4'd0, 32'd1, 1'b0, 31'd0);
		issue(CMD_CREATE, 4'd0, 32'd9, 1'b1, 31'd0);
		issue(3'd6, 4'hf, 32'hffffffff, 1'b1, RUN_WRAP);
		issue(3'd7, 4'h5, 32'h12345678, 1'b0, 31'h2aaaaaaa);
	endtask

	task automatic test_expiry();
		issue(CMD_CREATE, 4'd7, 32'hffffffff, 1'b1, 31'd0);
		issue(CMD_CREATE, 4'd1, 32'd0, 1'b1, 31'd0);
		issue(CMD_CREATE, 4'd2, 32'd2, 1'b1, 31'd0);
		issue(CMD_TICK, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_CHECK, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_CHECK, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_TICK, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_TICK, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_TICK, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_DELETE, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_CHECK, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_CREATE, 4'd0, 32'd3, 1'b0, 31'd0);
		issue(CMD_CHECK, 4'd0, 32'd0, 1'b0, 31'd0);
		issue(CMD_ELAPSED, 4'd0, 32'd0, 1'b0, 31'h7ffffffe);
		issue(CMD_READ, 4'd0, 32'd0, 1'b0, 31'd0);
	endtask

	task automatic test_random_phase(input int items, input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int n = 0; n < items; n++) begin
			send_request(random_request());
			sender_gap();
			// hold off now and then until the bank has answered everything
			if ($urandom_range(49) == 0) wait_for_idle_bank();
		end
		wait_for_idle_bank();
	endtask

	initial begin
		run_count = '0;
		for (int i = 0; i < TIMERS; i++) begin
			timer_left[i] = '0;
			timer_reload[i] = '0;
			timer_fired[i] = 1'b0;
			timer_auto[i] = 1'b0;
			timer_busy[i] = 1'b0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_id_and_usage();
		test_expiry();
		wait_for_idle_bank();
		test_random_phase(225, 0, 0);
		test_random_phase(225, 87, 0);
		test_random_phase(225, 0, 87);
		test_random_phase(225, 12, 12);
		wait_for_idle_bank();
		repeat (TIMERS * 4) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/stb_pkg.sv
sv/stb_ram.sv
sv/soft_timer_bank.sv
sim/soft_timer_bank_tb.sv
